### rtl/rah_pkg.sv
// ----------------------------------------------------------------------------
// rah_pkg
// Shared types and constants of the ray versus axis-aligned rectangle tester.
// ----------------------------------------------------------------------------
package rah_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned FRAC_BITS  = 16;
  localparam logic [31:0] FIX_ONE    = 32'd1 << FRAC_BITS;
  localparam int unsigned TQ_W       = 33;
  localparam int unsigned UV_W       = 17;

  typedef enum logic [2:0] {
    REG_PLANE_AXIS,
    REG_PLANE_POS,
    REG_SPAN1_LO,
    REG_SPAN1_HI,
    REG_SPAN2_LO,
    REG_SPAN2_HI,
    REG_MATERIAL,
    REG_INVERT
  } rah_reg_e;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z,
    AXIS_NONE
  } rah_axis_e;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] pos;
    logic signed [31:0] s1_lo;
    logic signed [31:0] s1_hi;
    logic signed [31:0] s2_lo;
    logic signed [31:0] s2_hi;
    logic [15:0]        material;
    logic               invert;
  } rah_cfg_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] tlo;
    logic signed [31:0] thi;
    logic               neg;
    logic               qneg;
    logic               miss;
  } rah_sb_t;

  typedef struct packed {
    logic               hit;
    logic               neg;
    logic               du_zero;
    logic               dv_zero;
    logic signed [31:0] t;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } rah_fsb_t;

endpackage

### rtl/rah_ray_if.sv
// ----------------------------------------------------------------------------
// rah_ray_if
// Ray input channel: origin, direction and t window with valid/ready.
// ----------------------------------------------------------------------------
interface rah_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic signed [31:0] t_lower;
  logic signed [31:0] t_upper;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper,
    output ready
  );
endinterface

### rtl/rah_hit_if.sv
// ----------------------------------------------------------------------------
// rah_hit_if
// Hit result channel with valid/ready.
// ----------------------------------------------------------------------------
interface rah_hit_if;
  logic               valid;
  logic               ready;
  logic               is_hit;
  logic signed [31:0] hit_t;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [16:0]        coord_u;
  logic [16:0]        coord_v;
  logic               faces_front;
  logic               normal_negative;
  logic [15:0]        hit_material;

  modport source (
    output valid, is_hit, hit_t, point_x, point_y, point_z, coord_u, coord_v,
           faces_front, normal_negative, hit_material,
    input  ready
  );
  modport sink (
    input  valid, is_hit, hit_t, point_x, point_y, point_z, coord_u, coord_v,
           faces_front, normal_negative, hit_material,
    output ready
  );
endinterface

### rtl/rah_cfg.sv
// ----------------------------------------------------------------------------
// rah_cfg
// APB register file holding the rectangle description.
// ----------------------------------------------------------------------------
module rah_cfg import rah_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output rah_cfg_t              cfg_o
);

  rah_cfg_t cfg_q, cfg_d;
  rah_reg_e sel;

  assign sel    = rah_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (sel)
        REG_PLANE_AXIS: cfg_d.axis     = pwdata[1:0];
        REG_PLANE_POS:  cfg_d.pos      = pwdata;
        REG_SPAN1_LO:   cfg_d.s1_lo    = pwdata;
        REG_SPAN1_HI:   cfg_d.s1_hi    = pwdata;
        REG_SPAN2_LO:   cfg_d.s2_lo    = pwdata;
        REG_SPAN2_HI:   cfg_d.s2_hi    = pwdata;
        REG_MATERIAL:   cfg_d.material = pwdata[15:0];
        REG_INVERT:     cfg_d.invert   = pwdata[0];
        default:        cfg_d          = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PLANE_AXIS: prdata = {30'd0, cfg_q.axis};
      REG_PLANE_POS:  prdata = cfg_q.pos;
      REG_SPAN1_LO:   prdata = cfg_q.s1_lo;
      REG_SPAN1_HI:   prdata = cfg_q.s1_hi;
      REG_SPAN2_LO:   prdata = cfg_q.s2_lo;
      REG_SPAN2_HI:   prdata = cfg_q.s2_hi;
      REG_MATERIAL:   prdata = {16'd0, cfg_q.material};
      REG_INVERT:     prdata = {31'd0, cfg_q.invert};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis     <= AXIS_Y;
      cfg_q.pos      <= 32'sd0;
      cfg_q.s1_lo    <= 32'sd0;
      cfg_q.s1_hi    <= FIX_ONE;
      cfg_q.s2_lo    <= 32'sd0;
      cfg_q.s2_hi    <= FIX_ONE;
      cfg_q.material <= 16'd0;
      cfg_q.invert   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/rah_tdiv.sv
// ----------------------------------------------------------------------------
// rah_tdiv
// Pipelined restoring divider for the ray parameter, one quotient bit a stage.
// ----------------------------------------------------------------------------
module rah_tdiv import rah_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     rem_i,
  input  logic [32:0]     nlow_i,
  input  logic [31:0]     dmag_i,
  input  rah_sb_t         sb_i,
  output logic            valid_o,
  output logic [TQ_W-1:0] quo_o,
  output rah_sb_t         sb_o
);

  logic            v_q   [TQ_W];
  logic [31:0]     rem_q [TQ_W];
  logic [32:0]     nl_q  [TQ_W];
  logic [TQ_W-1:0] quo_q [TQ_W];
  logic [31:0]     dm_q  [TQ_W];
  rah_sb_t         sb_q  [TQ_W];

  for (genvar j = 0; j < TQ_W; j++) begin : g_step
    logic            v_in;
    logic [31:0]     rem_in;
    logic [32:0]     nl_in;
    logic [TQ_W-1:0] quo_in;
    logic [31:0]     dm_in;
    rah_sb_t         sb_in;
    logic [32:0]     trial;
    logic [32:0]     diff;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign nl_in  = nlow_i;
      assign quo_in = '0;
      assign dm_in  = dmag_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign rem_in = rem_q[j-1];
      assign nl_in  = nl_q[j-1];
      assign quo_in = quo_q[j-1];
      assign dm_in  = dm_q[j-1];
      assign sb_in  = sb_q[j-1];
    end

    assign trial = {rem_in, nl_in[32]};
    assign ge    = trial >= {1'b0, dm_in};
    assign diff  = trial - {1'b0, dm_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? diff[31:0] : trial[31:0];
        nl_q[j]  <= {nl_in[31:0], 1'b0};
        quo_q[j] <= {quo_in[TQ_W-2:0], ge};
        dm_q[j]  <= dm_in;
        sb_q[j]  <= sb_in;
      end
    end
  end

  assign valid_o = v_q[TQ_W-1];
  assign quo_o   = quo_q[TQ_W-1];
  assign sb_o    = sb_q[TQ_W-1];

endmodule

### rtl/rah_fdiv.sv
// ----------------------------------------------------------------------------
// rah_fdiv
// Two-lane pipelined divider for the u and v fractions, one bit a stage.
// ----------------------------------------------------------------------------
module rah_fdiv import rah_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [32:0]     num_i [2],
  input  logic [32:0]     den_i [2],
  input  rah_fsb_t        sb_i,
  output logic            valid_o,
  output logic [UV_W-1:0] quo_o [2],
  output rah_fsb_t        sb_o
);

  logic            v_q   [UV_W];
  logic [33:0]     rem_q [UV_W][2];
  logic [32:0]     den_q [UV_W][2];
  logic [UV_W-1:0] quo_q [UV_W][2];
  rah_fsb_t        sb_q  [UV_W];

  for (genvar j = 0; j < UV_W; j++) begin : g_step
    logic     v_in;
    rah_fsb_t sb_in;

    if (j == 0) begin : g_first
      assign v_in  = valid_i;
      assign sb_in = sb_i;
    end else begin : g_next
      assign v_in  = v_q[j-1];
      assign sb_in = sb_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb_q[j] <= sb_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [33:0]     rem_in;
      logic [32:0]     den_in;
      logic [UV_W-1:0] quo_in;
      logic [33:0]     diff;
      logic [33:0]     kept;
      logic            ge;

      if (j == 0) begin : g_first
        assign rem_in = {1'b0, num_i[l]};
        assign den_in = den_i[l];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[j-1][l];
        assign den_in = den_q[j-1][l];
        assign quo_in = quo_q[j-1][l];
      end

      assign ge   = rem_in >= {1'b0, den_in};
      assign diff = rem_in - {1'b0, den_in};
      assign kept = ge ? diff : rem_in;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= {kept[32:0], 1'b0};
          den_q[j][l] <= den_in;
          quo_q[j][l] <= {quo_in[UV_W-2:0], ge};
        end
      end
    end
  end

  assign valid_o  = v_q[UV_W-1];
  assign quo_o[0] = quo_q[UV_W-1][0];
  assign quo_o[1] = quo_q[UV_W-1][1];
  assign sb_o     = sb_q[UV_W-1];

endmodule

### rtl/ray_aligned_rect_hit_top.sv
// ----------------------------------------------------------------------------
// ray_aligned_rect_hit_top
// Ray versus axis-aligned rectangle hit test, fully pipelined.
// ----------------------------------------------------------------------------
// One ray word is accepted every cycle while the output is not stalled, and one
// result word leaves for each, in order. From acceptance to the result register
// a ray passes two setup stages, 33 stages of the pipelined divider that forms t,
// a window stage, a multiply stage, a point add stage, a span check stage,
// 17 stages of the two-lane divider that forms u and v, and the output
// register. The whole pipeline holds while a result waits at the output.
// Configuration must only be written while the pipeline is empty.
module ray_aligned_rect_hit_top import rah_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  rah_ray_if.sink               ray_i,
  rah_hit_if.source             hit_o
);

  localparam int unsigned NUM_W = 33 + FRAC_BITS;

  rah_cfg_t cfg;
  logic     en;

  rah_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  function automatic logic signed [31:0] sat32(input logic signed [65:0] p);
    logic signed [31:0] r;
    if (!p[65] && (|p[64:31])) r = 32'sh7fffffff;
    else if (p[65] && !(&p[64:31])) r = 32'sh80000000;
    else r = p[31:0];
    return r;
  endfunction

  // stage a: axis select, numerator and divisor magnitudes
  logic signed [31:0] o_ax, d_ax;
  logic               ax_bad;
  logic signed [32:0] num;
  logic               a_v_q;
  logic [32:0]        a_nmag_q;
  logic [31:0]        a_dmag_q;
  rah_sb_t            a_sb_q, a_sb_d;

  always_comb begin
    ax_bad = 1'b0;
    case (rah_axis_e'(cfg.axis))
      AXIS_X: begin
        o_ax = ray_i.origin_x;
        d_ax = ray_i.dir_x;
      end
      AXIS_Y: begin
        o_ax = ray_i.origin_y;
        d_ax = ray_i.dir_y;
      end
      AXIS_Z: begin
        o_ax = ray_i.origin_z;
        d_ax = ray_i.dir_z;
      end
      default: begin
        o_ax   = 32'sd0;
        d_ax   = 32'sd0;
        ax_bad = 1'b1;
      end
    endcase
  end

  assign num = {cfg.pos[31], cfg.pos} - {o_ax[31], o_ax};

  always_comb begin
    a_sb_d.ox   = ray_i.origin_x;
    a_sb_d.oy   = ray_i.origin_y;
    a_sb_d.oz   = ray_i.origin_z;
    a_sb_d.dx   = ray_i.dir_x;
    a_sb_d.dy   = ray_i.dir_y;
    a_sb_d.dz   = ray_i.dir_z;
    a_sb_d.tlo  = ray_i.t_lower;
    a_sb_d.thi  = ray_i.t_upper;
    a_sb_d.neg  = d_ax[31];
    a_sb_d.qneg = num[32] ^ d_ax[31];
    a_sb_d.miss = ax_bad || (d_ax == 32'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= ray_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_nmag_q <= num[32] ? (33'd0 - num) : num;
      a_dmag_q <= d_ax[31] ? (32'd0 - d_ax) : d_ax;
      a_sb_q   <= a_sb_d;
    end
  end

  // stage b: scale numerator, overflow check, divider seed
  logic [NUM_W-1:0]     nfull;
  logic [FRAC_BITS-1:0] nhi;
  logic                 ovf;
  logic                 b_v_q;
  logic [31:0]          b_rem_q;
  logic [32:0]          b_nlow_q;
  logic [31:0]          b_dmag_q;
  rah_sb_t              b_sb_q, b_sb_d;

  assign nfull = {a_nmag_q, {FRAC_BITS{1'b0}}};
  assign nhi   = nfull[NUM_W-1:33];
  assign ovf   = 32'(nhi) >= a_dmag_q;

  always_comb begin
    b_sb_d      = a_sb_q;
    b_sb_d.miss = a_sb_q.miss || ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_rem_q  <= 32'(nhi);
      b_nlow_q <= nfull[32:0];
      b_dmag_q <= a_dmag_q;
      b_sb_q   <= b_sb_d;
    end
  end

  logic            dv_v;
  logic [TQ_W-1:0] dv_quo;
  rah_sb_t         dv_sb;

  rah_tdiv u_tdiv (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (b_v_q),
    .rem_i   (b_rem_q),
    .nlow_i  (b_nlow_q),
    .dmag_i  (b_dmag_q),
    .sb_i    (b_sb_q),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  // stage t: sign and window
  logic signed [33:0] tq, tlo_e, thi_e;
  logic               t_v_q, t_hit_q;
  logic signed [31:0] t_t_q;
  rah_sb_t            t_sb_q;

  assign tq    = dv_sb.qneg ? $signed(34'd0 - {1'b0, dv_quo}) : $signed({1'b0, dv_quo});
  assign tlo_e = $signed({{2{dv_sb.tlo[31]}}, dv_sb.tlo});
  assign thi_e = $signed({{2{dv_sb.thi[31]}}, dv_sb.thi});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_v_q <= 1'b0;
    end else if (en) begin
      t_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_hit_q <= !dv_sb.miss && (tq >= tlo_e) && (tq <= thi_e);
      t_t_q   <= tq[31:0];
      t_sb_q  <= dv_sb;
    end
  end

  // stage m: direction times t
  logic               m_v_q, m_hit_q;
  logic signed [31:0] m_t_q;
  logic signed [63:0] m_prod_q [3];
  rah_sb_t            m_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_hit_q     <= t_hit_q;
      m_t_q       <= t_t_q;
      m_sb_q      <= t_sb_q;
      m_prod_q[0] <= t_sb_q.dx * t_t_q;
      m_prod_q[1] <= t_sb_q.dy * t_t_q;
      m_prod_q[2] <= t_sb_q.dz * t_t_q;
    end
  end

  // stage p: hit point at full precision
  logic signed [31:0] m_o [3];
  logic               p_v_q, p_hit_q, p_neg_q;
  logic signed [31:0] p_t_q;
  logic signed [65:0] p_q [3];

  assign m_o[0] = m_sb_q.ox;
  assign m_o[1] = m_sb_q.oy;
  assign m_o[2] = m_sb_q.oz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= m_v_q;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_point
    logic signed [65:0] o_e, s_e;
    assign o_e = $signed({{34{m_o[i][31]}}, m_o[i]});
    assign s_e = $signed({{2{m_prod_q[i][63]}}, m_prod_q[i]}) >>> FRAC_BITS;
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[i] <= o_e + s_e;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_hit_q <= m_hit_q;
      p_neg_q <= m_sb_q.neg;
      p_t_q   <= m_t_q;
    end
  end

  // stage c: span check and fraction operands
  logic signed [65:0] p1, p2, l1_e, h1_e, l2_e, h2_e, n1, n2;
  logic [32:0]        den1, den2;
  logic               in_span;
  logic               c_v_q;
  logic [32:0]        c_num_q [2];
  logic [32:0]        c_den_q [2];
  rah_fsb_t           c_sb_q;

  assign p1   = (rah_axis_e'(cfg.axis) == AXIS_X) ? p_q[1] : p_q[0];
  assign p2   = (rah_axis_e'(cfg.axis) == AXIS_Z) ? p_q[1] : p_q[2];
  assign l1_e = $signed({{34{cfg.s1_lo[31]}}, cfg.s1_lo});
  assign h1_e = $signed({{34{cfg.s1_hi[31]}}, cfg.s1_hi});
  assign l2_e = $signed({{34{cfg.s2_lo[31]}}, cfg.s2_lo});
  assign h2_e = $signed({{34{cfg.s2_hi[31]}}, cfg.s2_hi});
  assign n1   = p1 - l1_e;
  assign n2   = p2 - l2_e;
  assign den1 = {cfg.s1_hi[31], cfg.s1_hi} - {cfg.s1_lo[31], cfg.s1_lo};
  assign den2 = {cfg.s2_hi[31], cfg.s2_hi} - {cfg.s2_lo[31], cfg.s2_lo};
  assign in_span = (p1 >= l1_e) && (p1 <= h1_e) && (p2 >= l2_e) && (p2 <= h2_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_num_q[0]     <= n1[32:0];
      c_num_q[1]     <= n2[32:0];
      c_den_q[0]     <= den1;
      c_den_q[1]     <= den2;
      c_sb_q.hit     <= p_hit_q && in_span;
      c_sb_q.neg     <= p_neg_q;
      c_sb_q.du_zero <= den1 == 33'd0;
      c_sb_q.dv_zero <= den2 == 33'd0;
      c_sb_q.t       <= p_t_q;
      c_sb_q.px      <= sat32(p_q[0]);
      c_sb_q.py      <= sat32(p_q[1]);
      c_sb_q.pz      <= sat32(p_q[2]);
    end
  end

  logic            fv_v;
  logic [UV_W-1:0] fv_quo [2];
  rah_fsb_t        fv_sb;

  rah_fdiv u_fdiv (
    .clk_i, .rst_ni,
    .en_i    (en),
    .valid_i (c_v_q),
    .num_i   (c_num_q),
    .den_i   (c_den_q),
    .sb_i    (c_sb_q),
    .valid_o (fv_v),
    .quo_o   (fv_quo),
    .sb_o    (fv_sb)
  );

  // output register
  logic               out_v_q;
  logic               o_hit_q, o_front_q, o_nneg_q;
  logic signed [31:0] o_t_q, o_px_q, o_py_q, o_pz_q;
  logic [16:0]        o_u_q, o_v_q;
  logic [15:0]        o_mat_q;
  logic               h;

  assign en          = !out_v_q || hit_o.ready;
  assign ray_i.ready = en;
  assign h           = fv_sb.hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= fv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_hit_q   <= h;
      o_t_q     <= h ? fv_sb.t : 32'sd0;
      o_px_q    <= h ? fv_sb.px : 32'sd0;
      o_py_q    <= h ? fv_sb.py : 32'sd0;
      o_pz_q    <= h ? fv_sb.pz : 32'sd0;
      o_u_q     <= (h && !fv_sb.du_zero) ? fv_quo[0] : 17'd0;
      o_v_q     <= (h && !fv_sb.dv_zero) ? fv_quo[1] : 17'd0;
      o_front_q <= h && (fv_sb.neg ^ cfg.invert);
      o_nneg_q  <= h && !fv_sb.neg;
      o_mat_q   <= h ? cfg.material : 16'd0;
    end
  end

  assign hit_o.valid           = out_v_q;
  assign hit_o.is_hit          = o_hit_q;
  assign hit_o.hit_t           = o_t_q;
  assign hit_o.point_x         = o_px_q;
  assign hit_o.point_y         = o_py_q;
  assign hit_o.point_z         = o_pz_q;
  assign hit_o.coord_u         = o_u_q;
  assign hit_o.coord_v         = o_v_q;
  assign hit_o.faces_front     = o_front_q;
  assign hit_o.normal_negative = o_nneg_q;
  assign hit_o.hit_material    = o_mat_q;

endmodule
